// ----- hw/rtl/csvjs_pkg.sv -----
// ----------------------------------------------------------------------------
// csvjs_pkg
// Types and character constants shared by the CSV to JSON field stream.
// ----------------------------------------------------------------------------
package csvjs_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int RES_CNT_W   = 3;   // holds 0..MAX_RESULTS
   localparam int RES_IDX_W   = 3;   // indexes MAX_RESULTS entries

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_FIELD = 2'd1;
   localparam logic [1:0] KIND_ROW   = 2'd2;

   // characters
   localparam logic [7:0] CHR_BS     = 8'h08;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_FF     = 8'h0C;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_ONE    = 8'h31;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_LC_B   = 8'h62;
   localparam logic [7:0] CHR_LC_F   = 8'h66;
   localparam logic [7:0] CHR_LC_N   = 8'h6E;
   localparam logic [7:0] CHR_LC_R   = 8'h72;
   localparam logic [7:0] CHR_LC_T   = 8'h74;
   localparam logic [7:0] CHR_LC_U   = 8'h75;
   localparam logic [7:0] HEX_LETTER = 8'h57;  // 'a' - 10
   localparam logic [7:0] CTRL_MAX   = 8'h1F;

   // line parser state, apart from the column counter
   typedef struct packed {
      logic       quoted;
      logic       quote_pending;
      logic [1:0] line_length;
      logic       line_only_cr;
      logic       on_first_line;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      quoted:        1'b0,
      quote_pending: 1'b0,
      line_length:   2'd0,
      line_only_cr:  1'b0,
      on_first_line: 1'b1
   };

   // all results caused by one input beat
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [MAX_RESULTS-1:0][1:0] kinds;
      logic [RES_CNT_W-1:0]        count;
   } bundle_type;

endpackage

// ----- hw/rtl/csvjs_parse.sv -----
// ----------------------------------------------------------------------------
// csvjs_parse
// Decodes one CSV byte against the line state: next state and the bundle of
// escaped content bytes and field/row markers the byte produces.
// ----------------------------------------------------------------------------
module csvjs_parse #(
   parameter int COLUMN_LIMIT = 256,
   parameter int CNT_W        = 8
) (
   input  csvjs_pkg::parse_state_type state,
   input  logic [CNT_W-1:0]           col,
   input  logic [7:0]                 in_byte,
   input  logic                       is_end,
   output csvjs_pkg::parse_state_type state_next,
   output logic [CNT_W-1:0]           col_next,
   output csvjs_pkg::bundle_type      bundle
);
   import csvjs_pkg::*;

   localparam logic [CNT_W-1:0] COL_MAX = CNT_W'(COLUMN_LIMIT - 1);

   function automatic bundle_type esc_bundle(input logic [7:0] c);
      bundle_type b;
      logic [7:0] s;
      b = '0;
      case (c)
         CHR_QUOTE:  s = CHR_QUOTE;
         CHR_BSLASH: s = CHR_BSLASH;
         CHR_BS:     s = CHR_LC_B;
         CHR_FF:     s = CHR_LC_F;
         CHR_LF:     s = CHR_LC_N;
         CHR_CR:     s = CHR_LC_R;
         CHR_TAB:    s = CHR_LC_T;
         default:    s = 8'd0;
      endcase
      if (s != 8'd0) begin
         b.data[0] = CHR_BSLASH;
         b.data[1] = s;
         b.count   = RES_CNT_W'(2);
      end else if (c <= CTRL_MAX) begin
         b.data[0] = CHR_BSLASH;
         b.data[1] = CHR_LC_U;
         b.data[2] = CHR_ZERO;
         b.data[3] = CHR_ZERO;
         b.data[4] = c[4] ? CHR_ONE : CHR_ZERO;
         b.data[5] = (c[3:0] < 4'd10) ? (CHR_ZERO + {4'd0, c[3:0]})
                                      : (HEX_LETTER + {4'd0, c[3:0]});
         b.count   = RES_CNT_W'(MAX_RESULTS);
      end else begin
         b.data[0] = c;
         b.count   = RES_CNT_W'(1);
      end
      return b;
   endfunction

   bundle_type row_close;
   bundle_type field_end;
   logic       kept;

   always_comb begin
      row_close          = '0;
      row_close.kinds[0] = KIND_FIELD;
      row_close.kinds[1] = KIND_ROW;
      row_close.count    = RES_CNT_W'(2);
      field_end          = '0;
      field_end.kinds[0] = KIND_FIELD;
      field_end.count    = RES_CNT_W'(1);
   end

   // skip empty lines and lines that are a lone CR, never the header line
   assign kept = state.on_first_line ||
                 !((state.line_length == 2'd0) ||
                   ((state.line_length == 2'd1) && state.line_only_cr));

   always_comb begin
      state_next = state;
      col_next   = col;
      bundle     = '0;
      if (is_end) begin
         if ((state.line_length != 2'd0) && kept) begin
            bundle = row_close;
         end
         state_next = PARSE_RESET;
         col_next   = '0;
      end else if (in_byte == CHR_LF) begin
         if (kept) begin
            bundle = row_close;
         end
         state_next               = PARSE_RESET;
         state_next.on_first_line = 1'b0;
         col_next                 = '0;
      end else begin
         if (state.line_length == 2'd0) begin
            state_next.line_only_cr = (in_byte == CHR_CR);
         end
         if (state.line_length != 2'd2) begin
            state_next.line_length = state.line_length + 2'd1;
         end
         if (state.quote_pending) begin
            state_next.quote_pending = 1'b0;
            if (in_byte == CHR_QUOTE) begin
               // doubled quote: literal quote, byte consumed
               bundle = esc_bundle(CHR_QUOTE);
            end else begin
               state_next.quoted = 1'b0;
            end
         end
         if (!(state.quote_pending && (in_byte == CHR_QUOTE))) begin
            if (state_next.quoted) begin
               if (in_byte == CHR_QUOTE) begin
                  state_next.quote_pending = 1'b1;
               end else begin
                  bundle = esc_bundle(in_byte);
               end
            end else if (in_byte == CHR_QUOTE) begin
               state_next.quoted = 1'b1;
            end else if (in_byte == CHR_COMMA) begin
               bundle = field_end;
               if (col < COL_MAX) begin
                  col_next = col + CNT_W'(1);
               end
            end else if (in_byte != CHR_CR) begin
               bundle = esc_bundle(in_byte);
            end
         end
      end
   end

endmodule

// ----- hw/rtl/csv_to_json_field_stream.sv -----
// ----------------------------------------------------------------------------
// csv_to_json_field_stream
// Streaming CSV field parser: emits JSON-escaped field bytes, field-end
// markers with column index and row-end markers.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_in_byte, req_is_end
//  rsp     | out | rsp_valid/rsp_ready  | rsp_out_byte, rsp_kind, rsp_column,
//          |     |                      | rsp_header_row, rsp_last
//
//  One result beat per cycle while rsp_ready is high. An input beat is parsed
//  in its accept cycle into a bundle register of up to six results, which
//  leave the output port one by one; a beat with no results leaves nothing.
//  The next input beat is taken in the cycle the bundle's last beat leaves.
//  Reset returns the parser to the start of a header line, bundle empty.
//  A stalled rsp side holds the bundle and blocks req.
// ----------------------------------------------------------------------------
module csv_to_json_field_stream #(
   parameter int COLUMN_LIMIT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_column,
   output logic       rsp_header_row,
   output logic       rsp_last
);
   import csvjs_pkg::*;

   localparam int CNT_W = $clog2(COLUMN_LIMIT);
   localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

   parse_state_type      state_ff, state_in;
   logic [CNT_W-1:0]     col_ff, col_in;
   bundle_type           bnd_ff, bnd_in;
   logic                 bnd_valid_ff;
   logic [RES_IDX_W-1:0] idx_ff;
   logic [EXT_W-1:0]     col_ext;
   logic [7:0]           col_out_ff;
   logic                 hdr_ff;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 at_last;

   csvjs_parse #(
      .COLUMN_LIMIT (COLUMN_LIMIT),
      .CNT_W        (CNT_W)
   ) u_parse (
      .state      (state_ff),
      .col        (col_ff),
      .in_byte    (req_in_byte),
      .is_end     (req_is_end),
      .state_next (state_in),
      .col_next   (col_in),
      .bundle     (bnd_in)
   );

   assign at_last   = (RES_CNT_W'(idx_ff) == (bnd_ff.count - RES_CNT_W'(1)));
   assign req_ready = !bnd_valid_ff || (rsp_ready && at_last);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign col_ext   = EXT_W'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PARSE_RESET;
         col_ff       <= '0;
         bnd_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (req_fire) begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         bnd_valid_ff <= (bnd_in.count != '0);
         idx_ff       <= '0;
      end else if (rsp_fire) begin
         // advance through the bundle, drop it after its last beat
         if (at_last) begin
            bnd_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + RES_IDX_W'(1);
         end
      end
   end

   // bundle payload: column and header flag as seen before the update
   always_ff @(posedge clock) begin
      if (req_fire) begin
         bnd_ff     <= bnd_in;
         col_out_ff <= col_ext[7:0];
         hdr_ff     <= state_ff.on_first_line;
      end
   end

   assign rsp_valid      = bnd_valid_ff;
   assign rsp_out_byte   = bnd_ff.data[idx_ff];
   assign rsp_kind       = bnd_ff.kinds[idx_ff];
   assign rsp_column     = col_out_ff;
   assign rsp_header_row = hdr_ff;
   assign rsp_last       = at_last;

endmodule

// ----- hw/rtl/csvjs_checker.sv -----
// ----------------------------------------------------------------------------
// csvjs_checker
// Port-level checks for the CSV to JSON field stream, bound to the top level.
// ----------------------------------------------------------------------------
module csvjs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_is_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_column,
   input logic       rsp_header_row,
   input logic       rsp_last
);
   import csvjs_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind) &&
         $stable(rsp_column) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // markers carry no byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_BYTE) |-> rsp_out_byte == 8'd0)
      else $error("marker beat with nonzero byte");

   // a row end closes the input beat
   a_row_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ROW) |-> rsp_last)
      else $error("row end not last");

   // a field end that is not last is followed by its row end
   a_field_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_FIELD) && !rsp_last |=>
         rsp_valid && (rsp_kind == KIND_ROW) && $stable(rsp_column))
      else $error("field end not followed by row end");

   // with nothing pending the input side is open
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

endmodule

bind csv_to_json_field_stream csvjs_checker u_csvjs_checker (.*);

// ----- verif/csv_to_json_field_stream_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_to_json_field_stream_tb
// Self-checking bench for the CSV to JSON field stream. A scoreboard class
// parses every accepted CSV beat itself and queues the escaped bytes, field
// ends and row ends it expects; every result beat is checked against the
// oldest entry. Stimulus runs a short directed pass, then random rows,
// blank lines, noise and end markers under several idle and stall mixes.
// ----------------------------------------------------------------------------
module csv_to_json_field_stream_tb;
   import csvjs_pkg::*;

   localparam int COLUMN_LIMIT = 256;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_BEATS  = 35;

   typedef struct packed {
      logic [7:0] data;
      logic       is_end;
   } csv_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [7:0] column;
      logic       header_row;
      logic       last;
   } json_beat_type;

   class json_field_scoreboard;
      json_beat_type pending_json_q[$];
      json_beat_type step_beats[$];
      int            errors;
      bit            quoted;
      bit            quote_pending;
      bit [1:0]      line_length;
      bit            line_only_cr;
      bit            on_first_line;
      int            column_count;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         quoted        = 1'b0;
         quote_pending = 1'b0;
         line_length   = 2'd0;
         line_only_cr  = 1'b0;
         on_first_line = 1'b1;
         column_count  = 0;
      endfunction

      function void emit(logic [7:0] data, logic [1:0] kind);
         json_beat_type r;
         r.data       = data;
         r.kind       = kind;
         r.column     = column_count[7:0];
         r.header_row = on_first_line;
         r.last       = 1'b0;
         step_beats.insert(step_beats.size(), r);
      endfunction

      function logic [7:0] hex_char(logic [3:0] v);
         return (v < 4'd10) ? CHR_ZERO + {4'd0, v} : HEX_LETTER + {4'd0, v};
      endfunction

      function void emit_escaped(logic [7:0] c);
         logic [7:0] short_code;
         short_code = 8'h00;
         case (c)
            CHR_QUOTE:  short_code = CHR_QUOTE;
            CHR_BSLASH: short_code = CHR_BSLASH;
            CHR_BS:     short_code = CHR_LC_B;
            CHR_FF:     short_code = CHR_LC_F;
            CHR_LF:     short_code = CHR_LC_N;
            CHR_CR:     short_code = CHR_LC_R;
            CHR_TAB:    short_code = CHR_LC_T;
            default:    short_code = 8'h00;
         endcase
         if (short_code != 8'h00) begin
            emit(CHR_BSLASH, KIND_BYTE);
            emit(short_code, KIND_BYTE);
         end else if (c <= CTRL_MAX) begin
            emit(CHR_BSLASH, KIND_BYTE);
            emit(CHR_LC_U, KIND_BYTE);
            emit(CHR_ZERO, KIND_BYTE);
            emit(CHR_ZERO, KIND_BYTE);
            emit(hex_char(c[7:4]), KIND_BYTE);
            emit(hex_char(c[3:0]), KIND_BYTE);
         end else begin
            emit(c, KIND_BYTE);
         end
      endfunction

      // header line is always kept; later empty or lone-CR lines are dropped
      function bit line_kept();
         if (on_first_line) return 1'b1;
         if (line_length == 2'd0) return 1'b0;
         if (line_length == 2'd1 && line_only_cr) return 1'b0;
         return 1'b1;
      endfunction

      function void close_row();
         emit(8'h00, KIND_FIELD);
         emit(8'h00, KIND_ROW);
      endfunction

      function void parse_csv_beat(logic [7:0] b, logic is_end);
         bit            take;
         json_beat_type r;
         step_beats.delete();
         if (is_end) begin
            if (line_length != 2'd0 && line_kept()) close_row();
            restart();
         end else if (b == CHR_LF) begin
            if (line_kept()) close_row();
            quoted        = 1'b0;
            quote_pending = 1'b0;
            line_length   = 2'd0;
            line_only_cr  = 1'b0;
            column_count  = 0;
            on_first_line = 1'b0;
         end else begin
            take = 1'b1;
            if (line_length == 2'd0) line_only_cr = (b == CHR_CR);
            if (line_length < 2'd2) line_length++;
            // a quote inside quotes waits one byte to see if it is doubled
            if (quote_pending) begin
               quote_pending = 1'b0;
               if (b == CHR_QUOTE) begin
                  emit_escaped(CHR_QUOTE);
                  take = 1'b0;
               end else begin
                  quoted = 1'b0;
               end
            end
            if (take) begin
               if (quoted) begin
                  if (b == CHR_QUOTE) quote_pending = 1'b1;
                  else emit_escaped(b);
               end else if (b == CHR_QUOTE) begin
                  quoted = 1'b1;
               end else if (b == CHR_COMMA) begin
                  emit(8'h00, KIND_FIELD);
                  if (column_count < COLUMN_LIMIT - 1) column_count++;
               end else if (b != CHR_CR) begin
                  emit_escaped(b);
               end
            end
         end
         if (step_beats.size() > 0) begin
            r = step_beats[step_beats.size() - 1];
            r.last = 1'b1;
            step_beats[step_beats.size() - 1] = r;
         end
         foreach (step_beats[i]) pending_json_q.insert(pending_json_q.size(), step_beats[i]);
      endfunction

      function void check_json_beat(json_beat_type got);
         json_beat_type want;
         if (pending_json_q.size() == 0) begin
            errors++;
            $display("%0t: expected none, got %h/%0d/%0d/%0b/%0b",
                     $time, got.data, got.kind, got.column, got.header_row, got.last);
            return;
         end
         want = pending_json_q.pop_front();
         if (got.data !== want.data || got.kind !== want.kind || got.column !== want.column ||
             got.header_row !== want.header_row || got.last !== want.last) begin
            errors++;
            $display("%0t: expected %h/%0d/%0d/%0b/%0b got %h/%0d/%0d/%0b/%0b",
                     $time, want.data, want.kind, want.column, want.header_row, want.last,
                     got.data, got.kind, got.column, got.header_row, got.last);
         end
      endfunction

      function int pending();
         return pending_json_q.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_is_end     = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_column;
   logic       rsp_header_row;
   logic       rsp_last;

   json_field_scoreboard sb;
   csv_beat_type stim_q[$];
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  pressure_go   = 1'b0;
   bit  hold_rsp      = 1'b0;
   int  cycle_count   = 0;

   csv_to_json_field_stream #(.COLUMN_LIMIT(COLUMN_LIMIT)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_is_end     (req_is_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_column     (rsp_column),
      .rsp_header_row (rsp_header_row),
      .rsp_last       (rsp_last)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // note inputs before results so a same-cycle result would still match
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.parse_csv_beat(req_in_byte, req_is_end);
         if (rsp_valid && rsp_ready)
            sb.check_json_beat('{data: rsp_out_byte, kind: rsp_kind, column: rsp_column,
                                 header_row: rsp_header_row, last: rsp_last});
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long receiver hold-off so the result side backs up into req
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   function void push_beat(logic [7:0] data, logic is_end);
      csv_beat_type beat;
      beat.data   = data;
      beat.is_end = is_end;
      stim_q.insert(stim_q.size(), beat);
   endfunction

   function logic [7:0] pick_text(bit quoted_text);
      logic [7:0] c;
      int         sel;
      sel = $urandom_range(99);
      if (sel < 55)      c = 8'($urandom_range(126, 32));
      else if (sel < 70) c = 8'($urandom_range(31, 0));
      else if (sel < 85) c = 8'($urandom_range(255, 128));
      else if (sel < 92) c = CHR_BSLASH;
      else               c = quoted_text ? CHR_COMMA : CHR_TAB;
      // keep framing characters out of field text
      if (c == CHR_QUOTE || c == CHR_LF || (!quoted_text && c == CHR_COMMA)) c = CHR_ONE;
      return c;
   endfunction

   function void gen_row();
      int nfields;
      int len;
      int sel;
      nfields = $urandom_range(6, 1);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) push_beat(CHR_COMMA, 1'b0);
         len = $urandom_range(5, 0);
         if ($urandom_range(2) == 0) begin
            push_beat(CHR_QUOTE, 1'b0);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(4) == 0) begin
                  push_beat(CHR_QUOTE, 1'b0);
                  push_beat(CHR_QUOTE, 1'b0);
               end else begin
                  push_beat(pick_text(1'b1), 1'b0);
               end
            end
            push_beat(CHR_QUOTE, 1'b0);
         end else begin
            for (int i = 0; i < len; i++) push_beat(pick_text(1'b0), 1'b0);
         end
      end
      sel = $urandom_range(99);
      if (sel < 65) begin
         push_beat(CHR_LF, 1'b0);
      end else if (sel < 88) begin
         push_beat(CHR_CR, 1'b0);
         push_beat(CHR_LF, 1'b0);
      end else begin
         push_beat(8'($urandom), 1'b1);
      end
   endfunction

   function void gen_blank();
      case ($urandom_range(3))
         0: push_beat(CHR_LF, 1'b0);
         1: begin
            push_beat(CHR_CR, 1'b0);
            push_beat(CHR_LF, 1'b0);
         end
         2: begin
            push_beat(CHR_CR, 1'b0);
            push_beat(8'($urandom), 1'b1);
         end
         default: push_beat(8'($urandom), 1'b1);
      endcase
   endfunction

   function void gen_noise();
      int len;
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(5))
            0: push_beat(CHR_QUOTE, 1'b0);
            1: push_beat(CHR_COMMA, 1'b0);
            2: push_beat(CHR_LF, 1'b0);
            3: push_beat(CHR_CR, 1'b0);
            default: push_beat(8'($urandom), 1'b0);
         endcase
      end
   endfunction

   // enough commas to drive the column counter into saturation; start clean
   // so a quote left open by earlier noise cannot swallow them
   function void gen_wide_row();
      push_beat(8'h00, 1'b1);
      for (int i = 0; i < 258; i++) begin
         if ($urandom_range(15) == 0) push_beat(pick_text(1'b0), 1'b0);
         push_beat(CHR_COMMA, 1'b0);
      end
      push_beat(pick_text(1'b0), 1'b0);
      push_beat(CHR_LF, 1'b0);
   endfunction

   function void gen_phase(int target);
      int sel;
      while (stim_q.size() < target) begin
         sel = $urandom_range(99);
         if (sel < 70)      gen_row();
         else if (sel < 82) gen_blank();
         else if (sel < 94) gen_noise();
         else               push_beat(8'($urandom), 1'b1);
      end
   endfunction

   task automatic send_beat(csv_beat_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= beat.data;
      req_is_end  <= beat.is_end;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_queue();
      while (stim_q.size() > 0) send_beat(stim_q.pop_front());
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty header line, lone-CR and empty lines to skip
      push_beat(CHR_LF, 1'b0);
      push_beat(CHR_CR, 1'b0);
      push_beat(CHR_LF, 1'b0);
      push_beat(CHR_LF, 1'b0);
      // quoted field with a doubled quote; closing quote right before LF
      push_beat(CHR_QUOTE, 1'b0);
      push_beat(8'h61, 1'b0);
      push_beat(CHR_QUOTE, 1'b0);
      push_beat(CHR_QUOTE, 1'b0);
      push_beat(CHR_LC_B, 1'b0);
      push_beat(CHR_QUOTE, 1'b0);
      push_beat(CHR_LF, 1'b0);
      // byte extremes, backslash, tab, FF, BS and control-code escapes, CR outside quotes dropped
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(CHR_BSLASH, 1'b0);
      push_beat(CHR_TAB, 1'b0);
      push_beat(CHR_FF, 1'b0);
      push_beat(CHR_BS, 1'b0);
      push_beat(CHR_CR, 1'b0);
      push_beat(CTRL_MAX, 1'b0);
      push_beat(CHR_COMMA, 1'b0);
      // LF inside quotes still ends the line
      push_beat(CHR_QUOTE, 1'b0);
      push_beat(CHR_LF, 1'b0);
      // quote opening mid-field, CR inside quotes, end closes the row
      push_beat(8'h78, 1'b0);
      push_beat(CHR_QUOTE, 1'b0);
      push_beat(CHR_CR, 1'b0);
      push_beat(8'hA5, 1'b1);
      push_beat(8'h5A, 1'b1);
      send_queue();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               pressure_go   = 1'b1;
            end
            1: begin
               send_idle_pct = 62;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 62;
               gen_wide_row();
            end
            default: begin
               send_idle_pct = 26;
               rsp_stall_pct = 26;
            end
         endcase
         gen_phase(stim_q.size() + PHASE_BEATS);
         send_queue();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/csvjs_pkg.sv
hw/rtl/csvjs_parse.sv
hw/rtl/csv_to_json_field_stream.sv
hw/rtl/csvjs_checker.sv
verif/csv_to_json_field_stream_tb.sv
